FILE: design/avs_pkg.sv
// ----------------------------------------------------------------------------
// Age-based victim selector package
// Shared widths, defaults and command codes for the victim selector.
// ----------------------------------------------------------------------------
`default_nettype none

package avs_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int STAMP_W       = 32;
    localparam int ENTRY_W       = 5;
    localparam int COUNT_W       = 6;
    localparam int VICTIM_W      = 5;
    localparam int USED_W        = 6;

    // Longest list that one command may return.
    localparam logic [COUNT_W-1:0] MAX_LIST  = 6'd32;
    localparam logic [USED_W-1:0]  USED_SAT  = 6'd63;
    localparam logic [STAMP_W-1:0] MIN_AGE_RESET = 32'd2;
    // Ages at or below this value are never listed.
    localparam logic [STAMP_W-1:0] LIST_AGE_FLOOR = 32'd1;

    typedef enum logic [1:0] {
        CMD_MARK  = 2'd0,
        CMD_EVICT = 2'd1,
        CMD_FIND  = 2'd2,
        CMD_LIST  = 2'd3
    } cmd_t;

endpackage

`default_nettype wire

FILE: design/age_based_victim_selector_top.sv
// ----------------------------------------------------------------------------
// Age-based victim selector
// Entry table with per-entry use stamps; finds and lists the oldest entries.
// ----------------------------------------------------------------------------
// A command transaction is taken when start is high and busy is low. Mark
// used and evict update the table at that edge and produce no result; busy
// stays low, so a further command may follow in the next cycle.
// Find oldest and list oldest scan the stamp memory through one shared
// subtract and compare unit, one entry per cycle. A scan pass reads the stamp
// memory once per entry in ST_SCAN, compares the registered read data of the
// last entry in ST_WAIT and settles the result in ST_EMIT.
// Find oldest puts its single result out at the end of its one scan pass.
// List oldest runs one pass per listed entry; each result appears at the end
// of the pass that finds its successor (or the pass that finds none), or
// from ST_FLUSH after the pass in which the count limit ends the list.
// Results appear for exactly one cycle, flagged by result_valid; the receiver
// cannot stall them. busy falls in the cycle of the final result.
// The min_age register is written through cfg_valid/cfg_ready/cfg_data,
// always ready; write it only while busy is low.
// Reset clears every valid bit and sets min_age to 2; stamps are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module age_based_victim_selector_top #(
    parameter int DEPTH = avs_pkg::DEPTH_DEFAULT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output logic                              busy,
    input  wire logic [1:0]                   command,
    input  wire logic [avs_pkg::ENTRY_W-1:0]  entry,
    input  wire logic [avs_pkg::STAMP_W-1:0]  frame,
    input  wire logic [avs_pkg::COUNT_W-1:0]  count,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [avs_pkg::STAMP_W-1:0]  cfg_data,
    output logic                              result_valid,
    output logic [avs_pkg::VICTIM_W-1:0]      victim,
    output logic [avs_pkg::STAMP_W-1:0]       age,
    output logic                              found,
    output logic [avs_pkg::USED_W-1:0]        used_now,
    output logic                              last
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int VW    = avs_pkg::VICTIM_W;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_EMIT,
        ST_FLUSH
    } state_t;

    state_t                         state_reg;
    logic [avs_pkg::STAMP_W-1:0]    min_age_reg;
    logic [DEPTH-1:0]               valid_reg;
    logic [DEPTH-1:0]               taken_reg;
    avs_pkg::cmd_t                  cmd_reg;
    logic [avs_pkg::STAMP_W-1:0]    frame_reg;
    logic [avs_pkg::COUNT_W-1:0]    limit_reg;
    logic [avs_pkg::COUNT_W-1:0]    listed_reg;
    logic                           first_pass_reg;
    logic [IDX_W-1:0]               ptr_reg;
    logic                           rd_pend_reg;
    logic [IDX_W-1:0]               rd_idx_reg;
    logic [avs_pkg::STAMP_W-1:0]    rd_data_reg;
    logic                           any_reg;
    logic [IDX_W-1:0]               best_idx_reg;
    logic [avs_pkg::STAMP_W-1:0]    best_age_reg;
    logic                           pend_reg;
    logic [IDX_W-1:0]               pend_idx_reg;
    logic [avs_pkg::STAMP_W-1:0]    pend_age_reg;
    logic [avs_pkg::USED_W-1:0]     used_reg;
    logic                           result_valid_reg;
    logic [VW-1:0]                  victim_reg;
    logic [avs_pkg::STAMP_W-1:0]    age_reg;
    logic                           found_reg;
    logic                           last_reg;

    logic [avs_pkg::STAMP_W-1:0]    stamp_mem [DEPTH];

    logic                           accept;
    logic                           entry_ok;
    logic [IDX_W-1:0]               entry_idx;
    avs_pkg::cmd_t                  cmd_in;
    logic [avs_pkg::STAMP_W-1:0]    age_cur;
    logic                           qualifies;
    logic                           better;
    logic                           cand;
    logic [avs_pkg::COUNT_W-1:0]    listed_next;

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign cmd_in    = avs_pkg::cmd_t'(command);
    assign entry_ok  = (32'(entry) < 32'(DEPTH));
    assign entry_idx = IDX_W'(entry);

    // Shared compare unit: age of the entry read last cycle against the best.
    assign age_cur   = frame_reg - rd_data_reg;
    assign qualifies = valid_reg[rd_idx_reg] && !taken_reg[rd_idx_reg] &&
                       ((cmd_reg != avs_pkg::CMD_LIST) ||
                        (age_cur > avs_pkg::LIST_AGE_FLOOR));
    assign better    = qualifies && (!any_reg || (age_cur > best_age_reg));
    assign cand        = any_reg && (listed_reg < limit_reg);
    assign listed_next = listed_reg + avs_pkg::COUNT_W'(1);

    // Stamp memory: one write port used by mark used, one registered read port.
    always_ff @(posedge clk)
    begin
        if (accept && (cmd_in == avs_pkg::CMD_MARK) && entry_ok)
        begin
            stamp_mem[entry_idx] <= frame;
        end
        rd_data_reg <= stamp_mem[ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            min_age_reg      <= avs_pkg::MIN_AGE_RESET;
            valid_reg        <= '0;
            taken_reg        <= '0;
            cmd_reg          <= avs_pkg::CMD_MARK;
            frame_reg        <= '0;
            limit_reg        <= '0;
            listed_reg       <= '0;
            first_pass_reg   <= 1'b0;
            ptr_reg          <= '0;
            rd_pend_reg      <= 1'b0;
            rd_idx_reg       <= '0;
            any_reg          <= 1'b0;
            best_idx_reg     <= '0;
            best_age_reg     <= '0;
            pend_reg         <= 1'b0;
            pend_idx_reg     <= '0;
            pend_age_reg     <= '0;
            used_reg         <= '0;
            result_valid_reg <= 1'b0;
            victim_reg       <= '0;
            age_reg          <= '0;
            found_reg        <= 1'b0;
            last_reg         <= 1'b0;
        end
        else
        begin
            result_valid_reg <= 1'b0;

            if (cfg_valid && cfg_ready)
            begin
                min_age_reg <= cfg_data;
            end

            // One read in flight behind the address pointer.
            rd_pend_reg <= (state_reg == ST_SCAN);
            rd_idx_reg  <= ptr_reg;

            if (rd_pend_reg)
            begin
                if (better)
                begin
                    any_reg      <= 1'b1;
                    best_idx_reg <= rd_idx_reg;
                    best_age_reg <= age_cur;
                end
                if (first_pass_reg && valid_reg[rd_idx_reg] &&
                    (rd_data_reg == frame_reg) && (used_reg != avs_pkg::USED_SAT))
                begin
                    used_reg <= used_reg + avs_pkg::USED_W'(1);
                end
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        unique case (cmd_in)
                            avs_pkg::CMD_MARK:
                            begin
                                if (entry_ok)
                                begin
                                    valid_reg[entry_idx] <= 1'b1;
                                end
                            end
                            avs_pkg::CMD_EVICT:
                            begin
                                if (entry_ok)
                                begin
                                    valid_reg[entry_idx] <= 1'b0;
                                end
                            end
                            avs_pkg::CMD_FIND, avs_pkg::CMD_LIST:
                            begin
                                cmd_reg        <= cmd_in;
                                frame_reg      <= frame;
                                limit_reg      <= (count > avs_pkg::MAX_LIST) ?
                                                  avs_pkg::MAX_LIST : count;
                                listed_reg     <= '0;
                                taken_reg      <= '0;
                                first_pass_reg <= 1'b1;
                                used_reg       <= '0;
                                any_reg        <= 1'b0;
                                pend_reg       <= 1'b0;
                                ptr_reg        <= '0;
                                state_reg      <= ST_SCAN;
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (ptr_reg == IDX_LAST)
                    begin
                        state_reg <= ST_WAIT;
                    end
                    else
                    begin
                        ptr_reg <= ptr_reg + IDX_W'(1);
                    end
                end
                ST_WAIT:
                begin
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    first_pass_reg <= 1'b0;
                    if (cmd_reg == avs_pkg::CMD_FIND)
                    begin
                        result_valid_reg <= 1'b1;
                        last_reg         <= 1'b1;
                        if (any_reg && (best_age_reg >= min_age_reg))
                        begin
                            found_reg  <= 1'b1;
                            victim_reg <= VW'(best_idx_reg);
                            age_reg    <= best_age_reg;
                        end
                        else
                        begin
                            found_reg  <= 1'b0;
                            victim_reg <= '0;
                            age_reg    <= '0;
                        end
                        state_reg <= ST_IDLE;
                    end
                    else if (cand)
                    begin
                        // The entry found is held back until it is known
                        // whether another follows, so that last is correct.
                        if (pend_reg)
                        begin
                            result_valid_reg <= 1'b1;
                            found_reg        <= 1'b1;
                            last_reg         <= 1'b0;
                            victim_reg       <= VW'(pend_idx_reg);
                            age_reg          <= pend_age_reg;
                        end
                        pend_reg                <= 1'b1;
                        pend_idx_reg            <= best_idx_reg;
                        pend_age_reg            <= best_age_reg;
                        taken_reg[best_idx_reg] <= 1'b1;
                        listed_reg              <= listed_next;
                        any_reg                 <= 1'b0;
                        ptr_reg                 <= '0;
                        if (listed_next == limit_reg)
                        begin
                            state_reg <= ST_FLUSH;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                    else
                    begin
                        result_valid_reg <= 1'b1;
                        last_reg         <= 1'b1;
                        found_reg        <= pend_reg;
                        victim_reg       <= pend_reg ? VW'(pend_idx_reg) : '0;
                        age_reg          <= pend_reg ? pend_age_reg : '0;
                        state_reg        <= ST_IDLE;
                    end
                end
                ST_FLUSH:
                begin
                    result_valid_reg <= 1'b1;
                    found_reg        <= 1'b1;
                    last_reg         <= 1'b1;
                    victim_reg       <= VW'(pend_idx_reg);
                    age_reg          <= pend_age_reg;
                    state_reg        <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign result_valid = result_valid_reg;
    assign victim       = victim_reg;
    assign age          = age_reg;
    assign found        = found_reg;
    assign used_now     = used_reg;
    assign last         = last_reg;

    // A result only ever closes a command that was in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
    else $error("result without a command in progress");

    // The final result of a command releases the block; any other keeps it busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (last == !busy))
    else $error("busy does not follow the last result");

    // An empty answer is always the only, and so the final, result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !found) |-> last)
    else $error("empty result not marked last");

endmodule

`default_nettype wire
